[rtl/core/pwps_pkg.sv]
package pwps_pkg;

   localparam int COORD_BITS      = 8;
   localparam int PHASE_BITS      = 24;
   localparam int SINE_TABLE_BITS = 10;
   localparam int ROUND_SHIFT     = PHASE_BITS - SINE_TABLE_BITS;
   localparam int QUAD_BITS       = SINE_TABLE_BITS - 2;
   localparam int QUAD_SIZE       = 1 << QUAD_BITS;
   localparam int SINE_BITS       = 31;
   localparam int AMP_BITS        = 32;
   localparam int OUT_BITS        = 32;
   localparam int SITE_BITS       = 16;
   localparam int COMP_BITS       = 4;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 32;
   localparam int PROD_BITS       = AMP_BITS + SINE_BITS;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [PHASE_BITS-1:0]      phase_type;
   typedef logic [SINE_TABLE_BITS-1:0] index_type;
   typedef logic [SINE_BITS-1:0]       sine_type;

   typedef struct packed {
      logic [SITE_BITS-1:0] site;
      logic [COMP_BITS-1:0] component;
   } tag_type;

   typedef struct packed {
      phase_type step_x;
      phase_type step_y;
      phase_type step_z;
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
   } geom_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP_X = 4'd0,
      CSR_PHASE_STEP_Y = 4'd1,
      CSR_PHASE_STEP_Z = 4'd2,
      CSR_ORIGIN_X     = 4'd3,
      CSR_ORIGIN_Y     = 4'd4,
      CSR_ORIGIN_Z     = 4'd5,
      CSR_AMPLITUDE    = 4'd6,
      CSR_SLICE_LOCAL  = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // sin(pi/2 * v / QUAD_SIZE) in Q30, truncated Taylor form
   function automatic logic [63:0] quarter_sine(input logic [63:0] v);
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      u  = v << (30 - QUAD_BITS);
      x  = (u * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      return (s > Q30_ONE) ? Q30_ONE : s;
   endfunction

   typedef sine_type sine_lut_type [QUAD_SIZE];

   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      for (int i = 0; i < QUAD_SIZE; i++) begin
         lut[i] = SINE_BITS'(quarter_sine(64'(i)));
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT  = build_sine_lut();
   localparam sine_type     SINE_FULL = SINE_BITS'(quarter_sine(64'(QUAD_SIZE)));

endpackage

[rtl/core/pwps_phase.sv]
module pwps_phase (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  pwps_pkg::coord_type coord_x,
   input  pwps_pkg::coord_type coord_y,
   input  pwps_pkg::coord_type coord_z,
   input  pwps_pkg::tag_type   in_tag,
   input  pwps_pkg::geom_type  geom,
   output logic                out_valid,
   output pwps_pkg::index_type out_index,
   output pwps_pkg::tag_type   out_tag
);

   localparam int MUL_BITS = pwps_pkg::PHASE_BITS + pwps_pkg::COORD_BITS + 2;

   logic                  s1_valid_ff;
   pwps_pkg::tag_type     s1_tag_ff;
   pwps_pkg::phase_type   term_x_ff, term_y_ff, term_z_ff;
   pwps_pkg::phase_type   term_x_in, term_y_in, term_z_in;

   logic                  s2_valid_ff;
   pwps_pkg::tag_type     s2_tag_ff;
   pwps_pkg::index_type   index_ff, index_in;

   logic [pwps_pkg::COORD_BITS:0] diff_x, diff_y, diff_z;
   logic signed [MUL_BITS-1:0] prod_x, prod_y, prod_z;
   pwps_pkg::phase_type   phase_sum, phase_rnd;

   // stage 1: signed axis offsets times step, modulo one turn
   always_comb begin
      diff_x = {1'b0, coord_x} - {1'b0, geom.origin_x};
      diff_y = {1'b0, coord_y} - {1'b0, geom.origin_y};
      diff_z = {1'b0, coord_z} - {1'b0, geom.origin_z};
      prod_x = $signed({1'b0, geom.step_x}) * $signed(diff_x);
      prod_y = $signed({1'b0, geom.step_y}) * $signed(diff_y);
      prod_z = $signed({1'b0, geom.step_z}) * $signed(diff_z);
      term_x_in = prod_x[pwps_pkg::PHASE_BITS-1:0];
      term_y_in = prod_y[pwps_pkg::PHASE_BITS-1:0];
      term_z_in = prod_z[pwps_pkg::PHASE_BITS-1:0];
   end

   // stage 2: sum and round to table index
   always_comb begin
      phase_sum = term_x_ff + term_y_ff + term_z_ff;
      phase_rnd = phase_sum + pwps_pkg::PHASE_BITS'(1 << (pwps_pkg::ROUND_SHIFT - 1));
      index_in  = phase_rnd[pwps_pkg::PHASE_BITS-1:pwps_pkg::ROUND_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff <= in_tag;
         term_x_ff <= term_x_in;
         term_y_ff <= term_y_in;
         term_z_ff <= term_z_in;
         s2_tag_ff <= s1_tag_ff;
         index_ff  <= index_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_index = index_ff;
   assign out_tag   = s2_tag_ff;

endmodule

[rtl/core/plane_wave_phase_source.sv]
// Plane-wave phase source: one lattice site in, one complex value out.
// Request channel (req_*): site coordinates, storage address, component.
// Response channel (rsp_*): address and component echoed, plus
// amplitude*cos(phase) and amplitude*sin(phase) as signed Q31, or zeros
// when the source slice is not on this node.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while idle, which the block does not enforce. A transfer
// happens on a channel when valid is high and stall is low. Five register
// stages: offset products, phase sum and rounding, quarter-wave table
// lookup, amplitude multiply, rounding/saturation into the output
// register. Throughput is one site per cycle while rsp_stall does not hold
// the pipeline. When rsp_stall is high with a response waiting, the whole
// pipeline holds and req_stall goes high; nothing is dropped or repeated.
// Reset clears the stage valids and the CSRs to zero, not the data regs.
module plane_wave_phase_source (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pwps_pkg::COORD_BITS-1:0]       req_coord_x,
   input  logic [pwps_pkg::COORD_BITS-1:0]       req_coord_y,
   input  logic [pwps_pkg::COORD_BITS-1:0]       req_coord_z,
   input  logic [pwps_pkg::SITE_BITS-1:0]        req_site_address,
   input  logic [pwps_pkg::COMP_BITS-1:0]        req_component,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pwps_pkg::SITE_BITS-1:0]        rsp_site_out,
   output logic [pwps_pkg::COMP_BITS-1:0]        rsp_component_out,
   output logic signed [pwps_pkg::OUT_BITS-1:0]  rsp_real_part,
   output logic signed [pwps_pkg::OUT_BITS-1:0]  rsp_imag_part,
   input  logic                                  csr_we,
   input  logic [pwps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pwps_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SUM_BITS = pwps_pkg::PROD_BITS + 1;
   localparam int SAT_BITS = SUM_BITS - (pwps_pkg::OUT_BITS - 1);

   pwps_pkg::geom_type                geom_ff;
   logic [pwps_pkg::AMP_BITS-1:0]     amplitude_ff;
   logic                              slice_local_ff;

   logic                              advance;

   pwps_pkg::tag_type                 req_tag;
   logic                              ph_valid;
   pwps_pkg::index_type               ph_index;
   pwps_pkg::tag_type                 ph_tag;

   logic                              s3_valid_ff;
   pwps_pkg::tag_type                 s3_tag_ff;
   pwps_pkg::sine_type                re_mag_ff, im_mag_ff, re_mag_in, im_mag_in;
   logic                              re_neg_ff, im_neg_ff, re_neg_in, im_neg_in;

   logic                              s4_valid_ff;
   pwps_pkg::tag_type                 s4_tag_ff;
   logic [pwps_pkg::PROD_BITS-1:0]    re_prod_ff, im_prod_ff, re_prod_in, im_prod_in;
   logic                              s4_re_neg_ff, s4_im_neg_ff;

   logic                              rsp_valid_ff;
   pwps_pkg::tag_type                 rsp_tag_ff;
   logic [pwps_pkg::OUT_BITS-1:0]     real_ff, imag_ff, real_in, imag_in;

   logic [pwps_pkg::QUAD_BITS-1:0]    rem;
   logic [pwps_pkg::QUAD_BITS-1:0]    rem_comp;
   pwps_pkg::sine_type                sin_r, sin_c;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff        <= '0;
         amplitude_ff   <= '0;
         slice_local_ff <= 1'b0;
      end else if (csr_we) begin
         case (pwps_pkg::csr_index_type'(csr_index))
            pwps_pkg::CSR_PHASE_STEP_X:
               geom_ff.step_x <= csr_wdata[pwps_pkg::PHASE_BITS-1:0];
            pwps_pkg::CSR_PHASE_STEP_Y:
               geom_ff.step_y <= csr_wdata[pwps_pkg::PHASE_BITS-1:0];
            pwps_pkg::CSR_PHASE_STEP_Z:
               geom_ff.step_z <= csr_wdata[pwps_pkg::PHASE_BITS-1:0];
            pwps_pkg::CSR_ORIGIN_X:
               geom_ff.origin_x <= csr_wdata[pwps_pkg::COORD_BITS-1:0];
            pwps_pkg::CSR_ORIGIN_Y:
               geom_ff.origin_y <= csr_wdata[pwps_pkg::COORD_BITS-1:0];
            pwps_pkg::CSR_ORIGIN_Z:
               geom_ff.origin_z <= csr_wdata[pwps_pkg::COORD_BITS-1:0];
            pwps_pkg::CSR_AMPLITUDE:
               amplitude_ff <= csr_wdata[pwps_pkg::AMP_BITS-1:0];
            pwps_pkg::CSR_SLICE_LOCAL:
               slice_local_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign req_tag.site      = req_site_address;
   assign req_tag.component = req_component;

   pwps_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .coord_z   (req_coord_z),
      .in_tag    (req_tag),
      .geom      (geom_ff),
      .out_valid (ph_valid),
      .out_index (ph_index),
      .out_tag   (ph_tag)
   );

   // stage 3: quarter-wave lookup and quadrant mapping
   always_comb begin
      rem      = ph_index[pwps_pkg::QUAD_BITS-1:0];
      rem_comp = pwps_pkg::QUAD_BITS'(0) - rem;
      sin_r    = pwps_pkg::SINE_LUT[rem];
      sin_c    = (rem == '0) ? pwps_pkg::SINE_FULL : pwps_pkg::SINE_LUT[rem_comp];
      case (pwps_pkg::quad_type'(ph_index[pwps_pkg::SINE_TABLE_BITS-1:pwps_pkg::QUAD_BITS]))
         pwps_pkg::QUAD_0: begin
            im_mag_in = sin_r;  im_neg_in = 1'b0;
            re_mag_in = sin_c;  re_neg_in = 1'b0;
         end
         pwps_pkg::QUAD_1: begin
            im_mag_in = sin_c;  im_neg_in = 1'b0;
            re_mag_in = sin_r;  re_neg_in = 1'b1;
         end
         pwps_pkg::QUAD_2: begin
            im_mag_in = sin_r;  im_neg_in = 1'b1;
            re_mag_in = sin_c;  re_neg_in = 1'b1;
         end
         default: begin
            im_mag_in = sin_c;  im_neg_in = 1'b1;
            re_mag_in = sin_r;  re_neg_in = 1'b0;
         end
      endcase
   end

   // stage 4: amplitude multiply
   always_comb begin
      re_prod_in = pwps_pkg::PROD_BITS'(amplitude_ff) * pwps_pkg::PROD_BITS'(re_mag_ff);
      im_prod_in = pwps_pkg::PROD_BITS'(amplitude_ff) * pwps_pkg::PROD_BITS'(im_mag_ff);
   end

   // stage 5: round half up, saturate, apply sign
   function automatic logic [pwps_pkg::OUT_BITS-1:0] scale_out(
      input logic [pwps_pkg::PROD_BITS-1:0] prod,
      input logic                           neg
   );
      logic [SUM_BITS-1:0]               sum;
      logic [SAT_BITS-1:0]               shifted;
      logic [pwps_pkg::OUT_BITS-1:0]     mag;
      sum     = SUM_BITS'(prod) + (SUM_BITS'(1) << (pwps_pkg::OUT_BITS - 2));
      shifted = sum[SUM_BITS-1:pwps_pkg::OUT_BITS-1];
      if (shifted[SAT_BITS-1:pwps_pkg::OUT_BITS-1] != '0) begin
         mag = {1'b0, {(pwps_pkg::OUT_BITS-1){1'b1}}};
      end else begin
         mag = pwps_pkg::OUT_BITS'(shifted);
      end
      return neg ? (pwps_pkg::OUT_BITS'(0) - mag) : mag;
   endfunction

   always_comb begin
      if (slice_local_ff) begin
         real_in = scale_out(re_prod_ff, s4_re_neg_ff);
         imag_in = scale_out(im_prod_ff, s4_im_neg_ff);
      end else begin
         real_in = '0;
         imag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff  <= ph_valid;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_tag_ff    <= ph_tag;
         re_mag_ff    <= re_mag_in;
         im_mag_ff    <= im_mag_in;
         re_neg_ff    <= re_neg_in;
         im_neg_ff    <= im_neg_in;
         s4_tag_ff    <= s3_tag_ff;
         re_prod_ff   <= re_prod_in;
         im_prod_ff   <= im_prod_in;
         s4_re_neg_ff <= re_neg_ff;
         s4_im_neg_ff <= im_neg_ff;
         rsp_tag_ff   <= s4_tag_ff;
         real_ff      <= real_in;
         imag_ff      <= imag_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_site_out      = rsp_tag_ff.site;
   assign rsp_component_out = rsp_tag_ff.component;
   assign rsp_real_part     = $signed(real_ff);
   assign rsp_imag_part     = $signed(imag_ff);

endmodule
